>>> rtl/krst_pkg.sv
// ----------------------------------------------------------------------------
// krst_pkg
// shared constants and types of the key repeat suppression table
// ----------------------------------------------------------------------------
package krst_pkg;

    localparam int SLOTS   = 32;
    localparam int KEY_W   = 16;
    localparam int TIMER_W = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    localparam logic [TIMER_W-1:0] DELAY_RESET = TIMER_W'(12);

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [TIMER_W-1:0] timer_t;

    // request from the sequencer to the slot store
    typedef struct packed {
        idx_t   raddr;
        logic   we_key;
        logic   we_timer;
        idx_t   waddr;
        key_t   wkey;
        timer_t wtimer;
    } krst_mem_req_t;

    // registered read data of the slot store
    typedef struct packed {
        key_t   rd_key;
        timer_t rd_timer;
    } krst_mem_rsp_t;

endpackage

>>> rtl/krst_store.sv
// ----------------------------------------------------------------------------
// krst_store
// slot key and slot timer memories, one write and one registered read port
// ----------------------------------------------------------------------------
module krst_store
    import krst_pkg::*;
(
    input  logic          clk,
    input  krst_mem_req_t mem_req,
    output krst_mem_rsp_t mem_rsp
);

    key_t   key_mem   [SLOTS];
    timer_t timer_mem [SLOTS];
    key_t   rd_key_reg;
    timer_t rd_timer_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we_key)
        begin
            key_mem[mem_req.waddr] <= mem_req.wkey;
        end
        if (mem_req.we_timer)
        begin
            timer_mem[mem_req.waddr] <= mem_req.wtimer;
        end
        rd_key_reg   <= key_mem[mem_req.raddr];
        rd_timer_reg <= timer_mem[mem_req.raddr];
    end

    assign mem_rsp.rd_key   = rd_key_reg;
    assign mem_rsp.rd_timer = rd_timer_reg;

endmodule

>>> rtl/krst_seq.sv
// ----------------------------------------------------------------------------
// krst_seq
// walks the used slots for one item: decrements timers on a tick, or looks
// up the key, picks a slot and updates its timer on a query
// ----------------------------------------------------------------------------
module krst_seq
    import krst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          item_func,
    input  key_t          item_key,
    input  logic          item_down,
    input  timer_t        delay,
    output logic          idle,
    output logic          res_valid,
    output logic          res_fire,
    input  logic          res_ready,
    output krst_mem_req_t mem_req,
    input  krst_mem_rsp_t mem_rsp
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_FIN    = 4'b1000
    } state_t;

    state_t state_reg,  state_next;
    cnt_t   used_reg,   used_next;
    cnt_t   issue_reg,  issue_next;
    logic   pend_reg,   pend_next;
    idx_t   pidx_reg,   pidx_next;
    logic   func_reg,   func_next;
    key_t   key_reg,    key_next;
    logic   down_reg,   down_next;
    logic   hit_reg,    hit_next;
    idx_t   hit_idx_reg,   hit_idx_next;
    timer_t hit_timer_reg, hit_timer_next;
    idx_t   best_idx_reg,   best_idx_next;
    timer_t best_timer_reg, best_timer_next;
    logic   fire_reg,   fire_next;

    idx_t   slot;
    timer_t cur_timer;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        down_next       = down_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_timer_next  = hit_timer_reg;
        best_idx_next   = best_idx_reg;
        best_timer_next = best_timer_reg;
        fire_next       = fire_reg;
        slot            = '0;
        cur_timer       = '0;

        mem_req.raddr    = issue_reg[IDX_W-1:0];
        mem_req.we_key   = 1'b0;
        mem_req.we_timer = 1'b0;
        mem_req.waddr    = pidx_reg;
        mem_req.wkey     = key_reg;
        mem_req.wtimer   = mem_rsp.rd_timer - 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = item_func;
                    key_next   = item_key;
                    down_next  = item_down;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    fire_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read of slot issue_reg, data back next cycle
                if (issue_reg < used_reg)
                begin
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + 1'b1;
                end
                else
                begin
                    state_next = (func_reg == FUNC_QUERY) ? S_DECIDE : S_FIN;
                end
                if (pend_reg)
                begin
                    if (func_reg == FUNC_TICK)
                    begin
                        mem_req.we_timer = (mem_rsp.rd_timer != '0);
                    end
                    else
                    begin
                        if (!hit_reg && mem_rsp.rd_key == key_reg)
                        begin
                            hit_next       = 1'b1;
                            hit_idx_next   = pidx_reg;
                            hit_timer_next = mem_rsp.rd_timer;
                        end
                        // strictly greater keeps the lowest index on a tie
                        if (pidx_reg == '0 || mem_rsp.rd_timer > best_timer_reg)
                        begin
                            best_idx_next   = pidx_reg;
                            best_timer_next = mem_rsp.rd_timer;
                        end
                    end
                end
            end
            S_DECIDE:
            begin
                if (hit_reg)
                begin
                    slot      = hit_idx_reg;
                    cur_timer = hit_timer_reg;
                end
                else if (used_reg < CNT_W'(SLOTS))
                begin
                    slot      = used_reg[IDX_W-1:0];
                    used_next = used_reg + 1'b1;
                end
                else
                begin
                    slot = best_idx_reg;
                end
                mem_req.we_key   = 1'b1;
                mem_req.we_timer = 1'b1;
                mem_req.waddr    = slot;
                if (down_reg)
                begin
                    mem_req.wtimer = (cur_timer == '0) ? delay : cur_timer;
                    fire_next      = (cur_timer == '0);
                end
                else
                begin
                    mem_req.wtimer = '0;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg      <= issue_next;
        pidx_reg       <= pidx_next;
        func_reg       <= func_next;
        key_reg        <= key_next;
        down_reg       <= down_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_timer_reg  <= hit_timer_next;
        best_idx_reg   <= best_idx_next;
        best_timer_reg <= best_timer_next;
        fire_reg       <= fire_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res_fire  = fire_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(SLOTS))
        else $error("slot count beyond table size");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("slot count moved by other than one");

    a_tick_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_fire) |-> (func_reg == FUNC_QUERY))
        else $error("fire on a tick");

    a_key_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we_key |-> (CNT_W'(mem_req.waddr) <= used_reg))
        else $error("key written beyond the used slots");
`endif

endmodule

>>> rtl/key_repeat_suppress_table.sv
// ----------------------------------------------------------------------------
// key_repeat_suppress_table
// repeat suppression table for key presses, slots held in on-chip memory
// ----------------------------------------------------------------------------
// items: one at a time, taken only while the sequencer is idle; each item
//   walks the used slots (at most SLOTS) with one read per cycle, a query
//   then writes its chosen slot, and the result is held in the output
//   register until it is taken
// reset: no slots in use, repeat delay 12, slot memories left uncleared
module key_repeat_suppress_table
    import krst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  logic   func,
    input  key_t   key_code,
    input  logic   key_down,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   fire,
    input  logic   cfg_valid,
    output logic   cfg_ready,
    input  timer_t cfg_data
);

    timer_t        delay_reg;
    logic          out_valid_reg;
    logic          fire_reg;
    logic          seq_idle;
    logic          res_valid;
    logic          res_fire;
    logic          res_ready;
    krst_mem_req_t mem_req;
    krst_mem_rsp_t mem_rsp;

    assign cfg_ready = 1'b1;
    assign in_ready  = seq_idle;
    // result register frees the sequencer once the result is taken
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= DELAY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                delay_reg <= cfg_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            fire_reg <= res_fire;
        end
    end

    assign out_valid = out_valid_reg;
    assign fire      = fire_reg;

    krst_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .item_func (func),
        .item_key  (key_code),
        .item_down (key_down),
        .delay     (delay_reg),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_fire  (res_fire),
        .res_ready (res_ready),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp)
    );

    krst_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

endmodule
